// ----- rtl/ffpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit page allocator
// Holds the default sizes, the command codes and the controller interface.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned DefHeapBytes   = 1048576;
  localparam int unsigned DefPageBytes   = 1024;
  localparam int unsigned DefHeaderBytes = 16;
  localparam int unsigned DefMaxChunks   = 1024;

  localparam int unsigned OffW = 20;
  localparam int unsigned ReqW = 21;
  localparam int unsigned LenW = 25;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture the item
    logic rd_cur;     // read the chain at the cursor
    logic step;       // advance cursor to next link
    logic rd_nb;      // read neighbours of the cursor
    logic do_alloc;   // perform allocate write-back
    logic do_free;    // perform free write-back step
    logic [1:0] wstep;
    logic fail;
    logic emit;
    logic clr;        // clearing pass write
  } ffpa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;
    logic at_end;
    logic clr_done;
  } ffpa_sts_t;

endpackage

// ----- rtl/ffpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram: generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/ffpa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_datapath: chunk tables, cursor and merge arithmetic
// Holds the chunk records in one memory and the spare slot stack in another.
// ----------------------------------------------------------------------------
module ffpa_datapath import ffpa_pkg::*; #(
  parameter int unsigned HeapBytes   = DefHeapBytes,
  parameter int unsigned PageBytes   = DefPageBytes,
  parameter int unsigned HeaderBytes = DefHeaderBytes,
  parameter int unsigned MaxChunks   = DefMaxChunks
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffpa_cmd_t       cmd_i,
  output ffpa_sts_t       sts_o,
  input  logic            command_i,
  input  logic [ReqW-1:0] request_bytes_i,
  input  logic [OffW-1:0] payload_offset_i,
  output logic [OffW-1:0] granted_offset_o,
  output logic            status_o
);
  localparam int unsigned SW = $clog2(MaxChunks);
  localparam int unsigned LW = SW + 1;
  localparam int unsigned PgSh = $clog2(PageBytes);
  localparam int unsigned RecW = OffW + LenW + 1 + 2 * LW;
  localparam logic [LW-1:0] NoLink = LW'(MaxChunks);
  localparam logic [LenW-1:0] Hdr = LenW'(HeaderBytes);

  typedef struct packed {
    logic [OffW-1:0] start;
    logic [LenW-1:0] len;
    logic            busy;
    logic [LW-1:0]   nxt;
    logic [LW-1:0]   prv;
  } rec_t;

  // Captured item.
  logic            cmd_q;
  logic [LenW-1:0] need_q;
  logic [OffW-1:0] off_q;
  logic [LenW-1:0] need_d;
  logic [ReqW-1:0] pages_w;

  always_comb begin
    pages_w = ReqW'((LenW'(request_bytes_i) + LenW'(PageBytes - 1)) >> PgSh);
    if (pages_w == '0) pages_w = ReqW'(1);
    need_d = LenW'(pages_w) << PgSh;
  end

  // Record memory, slot register, spare stack.
  logic          we;
  logic [SW-1:0] waddr, raddr;
  rec_t          wrec, rrec;
  logic [SW-1:0] cur_q, cur_d;
  rec_t          t_q, p_q, n_q;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          swe;
  logic [SW-1:0] swaddr, sraddr, swdata, srdata;
  logic [SW-1:0] clr_q;
  logic [1:0]    rph_q;
  logic          split;
  logic          pf, nf;

  ffpa_ram #(.Width(RecW), .Depth(MaxChunks)) u_rec (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wrec),
    .raddr_i(raddr), .rdata_o(rrec));

  ffpa_ram #(.Width(SW), .Depth(MaxChunks)) u_stk (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(swdata),
    .raddr_i(sraddr), .rdata_o(srdata));

  logic [OffW-1:0] t_pay;
  assign t_pay = rrec.start + OffW'(HeaderBytes);

  always_comb begin
    sts_o.clr_done = (clr_q == SW'(MaxChunks - 1));
    sts_o.at_end   = (rrec.nxt == NoLink);
    if (cmd_q == CmdFree) sts_o.hit = (t_pay == off_q);
    else                  sts_o.hit = !rrec.busy && (rrec.len >= need_q);
  end

  // Read address: cursor normally; neighbour phases use captured links, and
  // the first free write-back step fetches the survivor's new successor.
  always_comb begin
    raddr = cur_d;
    if (cmd_i.rd_nb) raddr = (rph_q == 2'd0) ? t_q.prv[SW-1:0] : t_q.nxt[SW-1:0];
    else if (cmd_i.do_free && cmd_i.wstep == 2'd0)
      raddr = nf ? n_q.nxt[SW-1:0] : t_q.nxt[SW-1:0];
    sraddr = (cnt_q == '0) ? '0 : SW'(cnt_q - LW'(1));
  end

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.load) cur_d = '0;
    else if (cmd_i.step) cur_d = rrec.nxt[SW-1:0];
  end

  // Write-back logic.
  assign pf = (t_q.prv != NoLink) && !p_q.busy;
  assign nf = (t_q.nxt != NoLink) && !n_q.busy;
  assign split = (t_q.nxt == NoLink) && (t_q.len - need_q > Hdr) && (cnt_q != '0);

  always_comb begin
    we = 1'b0; waddr = cur_q; wrec = t_q;
    swe = 1'b0; swaddr = SW'(cnt_q); swdata = cur_q;
    cnt_d = cnt_q;
    if (cmd_i.clr) begin
      we = 1'b1; waddr = '0;
      wrec = '{start: '0, len: LenW'(HeapBytes - HeaderBytes), busy: 1'b0,
               nxt: NoLink, prv: NoLink};
      swe = 1'b1; swaddr = clr_q; swdata = SW'(MaxChunks - 1) - clr_q;
    end else if (cmd_i.do_alloc) begin
      if (cmd_i.wstep == 2'd0) begin
        we = 1'b1; wrec.busy = 1'b1;
        if (split) begin
          wrec.len = need_q; wrec.nxt = LW'(srdata);
        end
      end else if (split) begin
        we = 1'b1; waddr = srdata;
        wrec = '{start: t_q.start + OffW'(HeaderBytes) + OffW'(need_q),
                 len: t_q.len - need_q - Hdr, busy: 1'b0, nxt: NoLink,
                 prv: LW'(cur_q)};
        cnt_d = cnt_q - LW'(1);
      end
    end else if (cmd_i.do_free) begin
      unique case (cmd_i.wstep)
        2'd0: begin
          // Survivor record.
          we = 1'b1;
          if (pf) begin
            waddr = t_q.prv[SW-1:0]; wrec = p_q;
            wrec.len = p_q.len + t_q.len + Hdr + (nf ? n_q.len + Hdr : '0);
            wrec.nxt = nf ? n_q.nxt : t_q.nxt;
          end else begin
            wrec.busy = 1'b0;
            if (nf) begin
              wrec.len = t_q.len + n_q.len + Hdr; wrec.nxt = n_q.nxt;
            end
          end
        end
        2'd1: begin
          // Successor back link.
          if (pf || nf) begin
            we = 1'b1;
            waddr = nf ? n_q.nxt[SW-1:0] : t_q.nxt[SW-1:0];
            wrec = rrec;
            wrec.prv = pf ? t_q.prv : LW'(cur_q);
            if ((nf ? n_q.nxt : t_q.nxt) == NoLink) we = 1'b0;
          end
          if (pf && cnt_q < LW'(MaxChunks)) begin
            swe = 1'b1; swdata = cur_q; cnt_d = cnt_q + LW'(1);
          end
        end
        2'd2: begin
          if (nf && cnt_q < LW'(MaxChunks)) begin
            swe = 1'b1; swdata = t_q.nxt[SW-1:0]; cnt_d = cnt_q + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= LW'(MaxChunks - 1);
      clr_q <= '0;
      cur_q <= '0;
      rph_q <= '0;
      granted_offset_o <= '0;
      status_o <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      if (cmd_i.clr) clr_q <= clr_q + SW'(1);
      rph_q <= cmd_i.rd_nb ? rph_q + 2'd1 : 2'd0;
      if (cmd_i.emit) begin
        granted_offset_o <= (cmd_q == CmdAlloc && !cmd_i.fail)
                            ? t_q.start + OffW'(HeaderBytes) : '0;
        status_o <= cmd_i.fail;
      end
    end
  end

  // Payload captures.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i; need_q <= need_d; off_q <= payload_offset_i;
    end
    if (cmd_i.rd_cur) t_q <= rrec;
    if (cmd_i.rd_nb && rph_q == 2'd1) p_q <= rrec;
    if (cmd_i.rd_nb && rph_q == 2'd2) n_q <= rrec;
  end
endmodule

// ----- rtl/ffpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl: sequencer of the allocator
// Walks the chain, fetches neighbours and steps through the write-back.
// ----------------------------------------------------------------------------
module ffpa_ctrl import ffpa_pkg::*; #(
  parameter int unsigned MaxChunks = DefMaxChunks
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      command_i,
  output logic      busy_o,
  output logic      done_o,
  output ffpa_cmd_t cmd_o,
  input  ffpa_sts_t sts_i
);
  localparam int unsigned SW = $clog2(MaxChunks);
  localparam int unsigned CntW = SW + 1;
  localparam logic [3:0] StClr = 4'd0, StIdle = 4'd1, StRd = 4'd2, StChk = 4'd3,
                         StNb0 = 4'd4, StNb1 = 4'd5, StNb2 = 4'd6, StNb3 = 4'd7,
                         StWr0 = 4'd8, StWr1 = 4'd9, StWr2 = 4'd10, StOut = 4'd11;

  logic [3:0] st_q, st_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic cmd_q, fail_q, fail_d;

  always_comb begin
    st_d = st_q; steps_d = steps_q; fail_d = fail_q;
    cmd_o = '0;
    cmd_o.fail = fail_q;
    unique case (st_q)
      StClr: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) st_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1; steps_d = '0; fail_d = 1'b0; st_d = StRd;
        end
      end
      StRd: st_d = StChk;
      StChk: begin
        steps_d = steps_q + CntW'(1);
        if (sts_i.hit) begin
          cmd_o.rd_cur = 1'b1;
          st_d = (cmd_q == CmdFree) ? StNb0 : StWr0;
        end else if (sts_i.at_end || steps_q == CntW'(MaxChunks - 1)) begin
          fail_d = (cmd_q == CmdAlloc); st_d = StOut;
        end else begin
          cmd_o.step = 1'b1; st_d = StRd;
        end
      end
      StNb0: begin cmd_o.rd_nb = 1'b1; st_d = StNb1; end
      StNb1: begin cmd_o.rd_nb = 1'b1; st_d = StNb2; end
      StNb2: begin cmd_o.rd_nb = 1'b1; st_d = StNb3; end
      StNb3: st_d = StWr0;
      StWr0: begin
        cmd_o.wstep = 2'd0;
        cmd_o.do_alloc = (cmd_q == CmdAlloc);
        cmd_o.do_free  = (cmd_q == CmdFree);
        st_d = StWr1;
      end
      StWr1: begin
        cmd_o.wstep = 2'd1;
        cmd_o.do_alloc = (cmd_q == CmdAlloc);
        cmd_o.do_free  = (cmd_q == CmdFree);
        st_d = StWr2;
      end
      StWr2: begin
        cmd_o.wstep = 2'd2;
        cmd_o.do_free = (cmd_q == CmdFree);
        st_d = StOut;
      end
      StOut: begin cmd_o.emit = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; steps_q <= '0; cmd_q <= 1'b0; fail_q <= 1'b0; done_o <= 1'b0;
    end else begin
      st_q <= st_d; steps_q <= steps_d; fail_q <= fail_d;
      done_o <= cmd_o.emit;
      if (cmd_o.load) cmd_q <= command_i;
    end
  end

  assign busy_o = (st_q != StIdle);
endmodule

// ----- rtl/first_fit_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator: first-fit heap allocator with coalescing
// Keeps an address-ordered chain of chunks and serves allocate and free items.
// ----------------------------------------------------------------------------
// Each chain link visited takes a read state and a check state; a free then
// fetches the neighbours and steps through the write-back, an allocate only
// through the write-back, and the result is registered from the output state.
// One item is in flight at a time; the chain walk through the single-read
// record memory sets the rate. The result strobe done_o lasts one cycle and
// cannot be stalled. After reset a clearing pass fills the spare slot stack.
module first_fit_page_allocator import ffpa_pkg::*; #(
  parameter int unsigned HeapBytes   = DefHeapBytes,
  parameter int unsigned PageBytes   = DefPageBytes,
  parameter int unsigned HeaderBytes = DefHeaderBytes,
  parameter int unsigned MaxChunks   = DefMaxChunks
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  input  logic            command_i,
  input  logic [ReqW-1:0] request_bytes_i,
  input  logic [OffW-1:0] payload_offset_i,
  output logic [OffW-1:0] granted_offset_o,
  output logic            status_o
);
  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  // The sequencer owns all control; the datapath owns all storage.
  ffpa_ctrl #(.MaxChunks(MaxChunks)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .command_i, .busy_o(busy), .done_o,
    .cmd_o(cmd), .sts_i(sts));

  ffpa_datapath #(
    .HeapBytes(HeapBytes), .PageBytes(PageBytes),
    .HeaderBytes(HeaderBytes), .MaxChunks(MaxChunks)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .command_i, .request_bytes_i,
    .payload_offset_i, .granted_offset_o, .status_o);

  // A failed allocate never carries an offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> granted_offset_o == '0) else $error("offset on failure");

  // A result follows only after the item was being worked on.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without work");

  // The block is back in idle, not busy, in the cycle that a result appears.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy at result");
endmodule
